>>> hdl/cdcs_pkg.sv
// ----------------------------------------------------------------------------
// cdcs_pkg: shared types and constants of the causal depthwise conv + SiLU
// Request and result structs, operation codes, sigmoid segment constants and
// small index-width helpers used by every module of the block.
// ----------------------------------------------------------------------------
package cdcs_pkg;

  parameter int CHANNEL_COUNT_DEF = 256;
  parameter int MAX_TAPS_DEF      = 4;

  // Operation codes of a request.
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  localparam logic [2:0] KT_RESET = 3'd4;

  // Sigmoid works on |acc| in Q.24. Magnitudes at or above 8.0 saturate the
  // result anyway, so the magnitude is clamped to 28 bits first.
  localparam int          MAG_W     = 28;
  localparam logic [27:0] MAG_CLAMP = 28'h800_0000;
  localparam logic [27:0] SIG_T_HI  = 28'd83886080;  // 5.0
  localparam logic [27:0] SIG_T_MID = 28'd39845888;  // 2.375
  localparam logic [27:0] SIG_T_LO  = 28'd16777216;  // 1.0
  localparam logic [16:0] SIG_OFS_HI  = 17'd55296;
  localparam logic [16:0] SIG_OFS_MID = 17'd40960;
  localparam logic [16:0] SIG_OFS_LO  = 17'd32768;
  localparam logic [16:0] Y_ONE       = 17'd65536;

  typedef struct packed {
    logic               op;
    logic [7:0]         channel;
    logic [1:0]         tap;
    logic signed [15:0] value;
    logic               seq_start;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] result;
    logic [7:0]         result_channel;
  } out_item_t;

  // Index width for a table of n entries, at least one bit.
  function automatic int idx_w(input int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

  // Number of history entries kept per channel, at least one.
  function automatic int hist_n(input int taps);
    return (taps > 1) ? taps - 1 : 1;
  endfunction

endpackage

>>> hdl/causal_depthwise_conv_silu_top.sv
// ----------------------------------------------------------------------------
// causal_depthwise_conv_silu_top: per-channel causal FIR followed by SiLU
// Channel  | Handshake                | Payload     | Meaning
// item     | item_valid / item_ready  | in_item_t   | weight load or sample
// res      | res_valid / res_ready    | out_item_t  | SiLU result per sample
// cfg      | cfg_we (no wait)         | cfg_data    | kernel_taps register
//
// A weight load leaves item_ready high. A sample goes through these steps
// before the next request is taken: one memory read, one multiply-accumulate
// per tap on the single shared multiplier, two SiLU stages, and a wait until
// the result register can take the result. A kernel_taps of zero uses one
// tap, values above MAX_TAPS use all. After reset the history memory is
// zeroed one row per cycle; item_ready stays low during that pass.
// The result register frees the core: a new request is taken while a result
// waits, and only the next result stalls until res_ready drains the register.
// ----------------------------------------------------------------------------
module causal_depthwise_conv_silu_top #(
  parameter int CHANNEL_COUNT = cdcs_pkg::CHANNEL_COUNT_DEF,
  parameter int MAX_TAPS      = cdcs_pkg::MAX_TAPS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  cdcs_pkg::in_item_t  item,
  output logic                res_valid,
  input  logic                res_ready,
  output cdcs_pkg::out_item_t res,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_data
);
  import cdcs_pkg::*;

  localparam int AW    = idx_w(CHANNEL_COUNT);
  localparam int TAW   = idx_w(MAX_TAPS);
  localparam int HW    = hist_n(MAX_TAPS);
  localparam int HAW   = idx_w(HW);
  // A Q8.24 product needs 32 signed bits; the sum grows by the tap count.
  localparam int ACC_W = 33 + TAW;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_MAC   = 2'd2;
  localparam logic [1:0] ST_ACT   = 2'd3;

  logic [1:0]             state;
  logic [2:0]             kernel_taps;
  logic [AW-1:0]          clr_addr;

  // Sample request captured at accept time.
  logic [AW-1:0]          ch_addr;
  logic [7:0]             cur_channel;
  logic signed [15:0]     cur_value;
  logic                   cur_start;
  logic [TAW-1:0]         klast;
  logic [TAW-1:0]         tap_idx;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] acc_next;

  logic                   accept;
  logic                   ch_ok;
  logic                   tap_ok;
  logic                   sample_go;
  logic [31:0]            ch32;
  logic [31:0]            tap32;
  logic [31:0]            kl32;
  logic [31:0]            hidx32;

  logic [MAX_TAPS-1:0][15:0] w_row;
  logic [HW-1:0][15:0]       h_row;
  logic [HW-1:0][15:0]       h_new;
  logic [HW-1:0][15:0]       h_wr_data;
  logic                      h_wr_en;
  logic [AW-1:0]             h_wr_addr;

  logic signed [15:0]     w_sel;
  logic signed [15:0]     s_sel;
  logic signed [31:0]     prod;

  logic                   silu_start;
  logic                   silu_done;
  logic signed [15:0]     silu_result;
  logic                   res_load;

  assign item_ready = (state == ST_IDLE);
  assign accept     = item_valid && item_ready;
  assign ch32       = 32'(item.channel);
  assign tap32      = 32'(item.tap);
  assign ch_ok      = ch32 < 32'(CHANNEL_COUNT);
  assign tap_ok     = tap32 < 32'(MAX_TAPS);
  assign sample_go  = accept && (item.op == OP_SAMPLE) && ch_ok;

  // Taps in use, minus one: zero acts as one tap, large values as MAX_TAPS.
  always_comb begin
    if (kernel_taps == 3'd0) begin
      kl32 = 32'd0;
    end else if (32'(kernel_taps) > 32'(MAX_TAPS)) begin
      kl32 = 32'(MAX_TAPS - 1);
    end else begin
      kl32 = 32'(kernel_taps) - 32'd1;
    end
  end

  cdcs_weight_mem #(
    .CHANNEL_COUNT (CHANNEL_COUNT),
    .MAX_TAPS      (MAX_TAPS)
  ) u_weight_mem (
    .clk     (clk),
    .wr_en   (accept && (item.op == OP_LOAD) && ch_ok && tap_ok),
    .wr_addr (ch32[AW-1:0]),
    .wr_lane (tap32[TAW-1:0]),
    .wr_data (item.value),
    .rd_en   (sample_go),
    .rd_addr (ch32[AW-1:0]),
    .rd_data (w_row)
  );

  // The history row is written back once, in the first accumulate cycle.
  // The next sample is read only after this item leaves, so no forwarding
  // path is needed between write-back and the following read.
  always_comb begin
    for (int j = 0; j < HW; j++) begin
      if (j == 0) begin
        h_new[j] = cur_value;
      end else begin
        h_new[j] = cur_start ? 16'd0 : h_row[j-1];
      end
    end
    if (state == ST_CLEAR) begin
      h_wr_en   = 1'b1;
      h_wr_addr = clr_addr;
      h_wr_data = '0;
    end else begin
      h_wr_en   = (state == ST_MAC) && (tap_idx == '0);
      h_wr_addr = ch_addr;
      h_wr_data = h_new;
    end
  end

  cdcs_hist_mem #(
    .CHANNEL_COUNT (CHANNEL_COUNT),
    .MAX_TAPS      (MAX_TAPS)
  ) u_hist_mem (
    .clk     (clk),
    .wr_en   (h_wr_en),
    .wr_addr (h_wr_addr),
    .wr_data (h_wr_data),
    .rd_en   (sample_go),
    .rd_addr (ch32[AW-1:0]),
    .rd_data (h_row)
  );

  // Tap t weighs the sample klast-t steps back; the last tap takes the
  // current sample. A sequence start reads the whole history as zero.
  always_comb begin
    hidx32 = 32'(klast) - 32'(tap_idx) - 32'd1;
    w_sel  = w_row[tap_idx];
    if (tap_idx == klast) begin
      s_sel = cur_value;
    end else if (cur_start) begin
      s_sel = 16'sd0;
    end else begin
      s_sel = h_row[hidx32[HAW-1:0]];
    end
    prod     = w_sel * s_sel;
    acc_next = acc + ACC_W'(prod);
  end

  assign silu_start = (state == ST_MAC) && (tap_idx == klast);
  assign res_load   = (state == ST_ACT) && silu_done && (!res_valid || res_ready);

  cdcs_silu #(
    .ACC_W (ACC_W)
  ) u_silu (
    .clk    (clk),
    .rst    (rst),
    .start  (silu_start),
    .acc    (acc_next),
    .take   (res_load),
    .done   (silu_done),
    .result (silu_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      clr_addr    <= '0;
      kernel_taps <= KT_RESET;
      res_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        kernel_taps <= cfg_data;
      end
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (32'(clr_addr) == 32'(CHANNEL_COUNT - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (sample_go) begin
            state <= ST_MAC;
          end
        end
        ST_MAC: begin
          if (tap_idx == klast) begin
            state <= ST_ACT;
          end
        end
        ST_ACT: begin
          if (res_load) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (sample_go) begin
      ch_addr     <= ch32[AW-1:0];
      cur_channel <= item.channel;
      cur_value   <= item.value;
      cur_start   <= item.seq_start;
      klast       <= kl32[TAW-1:0];
      tap_idx     <= '0;
      acc         <= '0;
    end else if (state == ST_MAC) begin
      acc     <= acc_next;
      tap_idx <= tap_idx + 1'b1;
    end
    if (res_load) begin
      res.result         <= silu_result;
      res.result_channel <= cur_channel;
    end
  end

endmodule

>>> hdl/cdcs_weight_mem.sv
// ----------------------------------------------------------------------------
// cdcs_weight_mem: tap weight memory
// One row per channel holding all tap weights. A load writes one lane of a
// row; a sample reads the whole row, and read data is registered.
// ----------------------------------------------------------------------------
module cdcs_weight_mem #(
  parameter int CHANNEL_COUNT = cdcs_pkg::CHANNEL_COUNT_DEF,
  parameter int MAX_TAPS      = cdcs_pkg::MAX_TAPS_DEF
) (
  input  logic                                          clk,
  input  logic                                          wr_en,
  input  logic [cdcs_pkg::idx_w(CHANNEL_COUNT)-1:0]     wr_addr,
  input  logic [cdcs_pkg::idx_w(MAX_TAPS)-1:0]          wr_lane,
  input  logic [15:0]                                   wr_data,
  input  logic                                          rd_en,
  input  logic [cdcs_pkg::idx_w(CHANNEL_COUNT)-1:0]     rd_addr,
  output logic [MAX_TAPS-1:0][15:0]                     rd_data
);
  import cdcs_pkg::*;

  logic [MAX_TAPS-1:0][15:0] mem [CHANNEL_COUNT];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr][wr_lane] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> hdl/cdcs_hist_mem.sv
// ----------------------------------------------------------------------------
// cdcs_hist_mem: sample history memory
// One row per channel holding the previous samples, newest in lane 0.
// Whole rows are read and written back; read data is registered.
// ----------------------------------------------------------------------------
module cdcs_hist_mem #(
  parameter int CHANNEL_COUNT = cdcs_pkg::CHANNEL_COUNT_DEF,
  parameter int MAX_TAPS      = cdcs_pkg::MAX_TAPS_DEF
) (
  input  logic                                          clk,
  input  logic                                          wr_en,
  input  logic [cdcs_pkg::idx_w(CHANNEL_COUNT)-1:0]     wr_addr,
  input  logic [cdcs_pkg::hist_n(MAX_TAPS)-1:0][15:0]   wr_data,
  input  logic                                          rd_en,
  input  logic [cdcs_pkg::idx_w(CHANNEL_COUNT)-1:0]     rd_addr,
  output logic [cdcs_pkg::hist_n(MAX_TAPS)-1:0][15:0]   rd_data
);
  import cdcs_pkg::*;

  logic [hist_n(MAX_TAPS)-1:0][15:0] mem [CHANNEL_COUNT];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> hdl/cdcs_silu.sv
// ----------------------------------------------------------------------------
// cdcs_silu: SiLU of the filter sum
// Stage one forms the clamped magnitude and the piecewise-linear sigmoid,
// stage two multiplies them; rounding and saturation follow at the output.
// ----------------------------------------------------------------------------
module cdcs_silu #(
  parameter int ACC_W = 35
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [ACC_W-1:0] acc,
  input  logic                    take,
  output logic                    done,
  output logic signed [15:0]      result
);
  import cdcs_pkg::*;

  logic [ACC_W-1:0] mag;
  logic [MAG_W-1:0] mag_c;
  logic [16:0]      y_pos;
  logic [16:0]      y_sel;

  logic             s1_valid;
  logic [MAG_W-1:0] s1_mag;
  logic [16:0]      s1_y;
  logic             s1_neg;

  logic             s2_neg;
  logic [44:0]      s2_prod;

  logic [45:0]      rnd;
  logic [17:0]      rm;

  always_comb begin
    mag = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
    if (mag >= ACC_W'(MAG_CLAMP)) begin
      mag_c = MAG_CLAMP;
    end else begin
      mag_c = mag[MAG_W-1:0];
    end
    if (mag_c >= SIG_T_HI) begin
      y_pos = Y_ONE;
    end else if (mag_c >= SIG_T_MID) begin
      y_pos = 17'(mag_c >> 13) + SIG_OFS_HI;
    end else if (mag_c >= SIG_T_LO) begin
      y_pos = 17'(mag_c >> 11) + SIG_OFS_MID;
    end else begin
      y_pos = 17'(mag_c >> 10) + SIG_OFS_LO;
    end
    y_sel = acc[ACC_W-1] ? Y_ONE - y_pos : y_pos;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      s1_valid <= start;
      if (s1_valid) begin
        done <= 1'b1;
      end else if (take) begin
        done <= 1'b0;
      end
    end
    if (start) begin
      s1_mag <= mag_c;
      s1_y   <= y_sel;
      s1_neg <= acc[ACC_W-1];
    end
    if (s1_valid) begin
      s2_prod <= 45'(s1_mag) * 45'(s1_y);
      s2_neg  <= s1_neg;
    end
  end

  // Round half away from zero on the magnitude, then saturate by sign.
  always_comb begin
    rnd = 46'(s2_prod) + 46'h800_0000;
    rm  = rnd[45:28];
    if (s2_neg) begin
      result = (rm > 18'd32768) ? 16'sh8000 : 16'(18'd0 - rm);
    end else begin
      result = (rm > 18'd32767) ? 16'sh7fff : rm[15:0];
    end
  end

endmodule

>>> hdl/cdcs_checker.sv
// ----------------------------------------------------------------------------
// cdcs_checker: port-level checks of the causal depthwise conv + SiLU
// Watches the top-level ports only and is bound to every instance.
// ----------------------------------------------------------------------------
module cdcs_checker #(
  parameter int CHANNEL_COUNT = cdcs_pkg::CHANNEL_COUNT_DEF
) (
  input logic                clk,
  input logic                rst,
  input logic                item_valid,
  input logic                item_ready,
  input cdcs_pkg::in_item_t  item,
  input logic                res_valid,
  input logic                res_ready,
  input cdcs_pkg::out_item_t res
);
  import cdcs_pkg::*;

  // The history clearing pass keeps requests out right after reset.
  a_clear_blocks: assert property (@(posedge clk) rst |=> !item_ready)
    else $error("request taken during history clearing pass");

  a_reset_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid right after reset");

  // A sample in range leaves the core busy after it is taken.
  a_sample_busy: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready && (item.op == OP_SAMPLE) &&
    (32'(item.channel) < 32'(CHANNEL_COUNT)) |=> !item_ready)
    else $error("core ready again one cycle after a sample");

  // Loads and ignored requests finish in their own cycle.
  a_load_quick: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready &&
    ((item.op == OP_LOAD) || (32'(item.channel) >= 32'(CHANNEL_COUNT)))
    |=> item_ready)
    else $error("load or ignored request stalled the core");

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("stalled result dropped or changed");

endmodule

bind causal_depthwise_conv_silu_top cdcs_checker #(
  .CHANNEL_COUNT (CHANNEL_COUNT)
) u_cdcs_checker (.*);

>>> sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for causal_depthwise_conv_silu_top
// Drives weight loads and samples through the request channel, predicts each
// SiLU result from a cycle-free model of the per-channel FIR and the
// piecewise sigmoid, and compares every accepted result in order.
// ----------------------------------------------------------------------------
module tb;
  import cdcs_pkg::*;

  localparam int NCH          = CHANNEL_COUNT_DEF;
  localparam int NTAPS        = MAX_TAPS_DEF;
  localparam int STALL_LIMIT  = 4000;  // covers the history clearing pass
  localparam int SETTLE       = 16;    // longer than one sample at 7 taps
  localparam int PHASE_ITEMS  = 160;

  // Sigmoid segment bounds on |acc| in Q.24.
  localparam longint SEG_SAT  = longint'(5) << 24;
  localparam longint SEG_HIGH = longint'(19) << 21;
  localparam longint SEG_LOW  = longint'(1) << 24;
  localparam longint Y_FULL   = 65536;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      item_valid = 1'b0;
  logic      item_ready;
  in_item_t  item = '0;
  logic      res_valid;
  logic      res_ready = 1'b0;
  out_item_t res;
  logic      cfg_we = 1'b0;
  logic [2:0] cfg_data = '0;

  // Shadow of the block: tap weights, per-channel history, tap count register.
  logic signed [15:0] tap_w [NCH][NTAPS];
  bit                 wt_loaded [NCH][NTAPS];
  logic signed [15:0] hist [NCH][NTAPS-1];
  logic [2:0]         kt_reg;

  out_item_t pending_silu[$];
  int        errors = 0;
  bit        idle_on = 1'b1;
  int        quiet_cycles = 0;

  causal_depthwise_conv_silu_top DUT (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data)
  );

  always #4 clk = ~clk;

  // Number of taps that the current register value puts to use: zero acts as
  // one tap and anything above the maximum acts as the maximum.
  function automatic int taps_in_use();
    if (kt_reg == 0) return 1;
    if (kt_reg > NTAPS) return NTAPS;
    return int'(kt_reg);
  endfunction

  // Applies one accepted request to the shadow state. A sample also yields
  // the expected SiLU result, which joins the queue of pending results.
  task automatic predict_silu(input in_item_t r);
    int                 k;
    longint             acc, m, y, rm;
    logic signed [15:0] v, out16;
    out_item_t          want;
    v = $signed(r.value);
    if (r.op == OP_LOAD) begin
      tap_w[r.channel][r.tap] = v;
      wt_loaded[r.channel][r.tap] = 1'b1;
      return;
    end
    k = taps_in_use();
    // A sequence start wipes the channel's history before the sum.
    if (r.seq_start)
      for (int j = 0; j < NTAPS - 1; j++) hist[r.channel][j] = '0;
    acc = longint'(tap_w[r.channel][k-1]) * longint'(v);
    for (int j = 0; j < k - 1; j++)
      acc += longint'(tap_w[r.channel][k-2-j]) * longint'(hist[r.channel][j]);
    for (int j = NTAPS - 2; j > 0; j--) hist[r.channel][j] = hist[r.channel][j-1];
    hist[r.channel][0] = v;

    m = (acc < 0) ? -acc : acc;
    if (m >= SEG_SAT)       y = Y_FULL;
    else if (m >= SEG_HIGH) y = (m >> 13) + 55296;
    else if (m >= SEG_LOW)  y = (m >> 11) + 40960;
    else                    y = (m >> 10) + 32768;
    if (acc < 0) y = Y_FULL - y;
    // Round half away from zero on the magnitude, then saturate by sign.
    rm = (m * y + (longint'(1) << 27)) >> 28;
    if (acc < 0) out16 = (rm > 32768) ? 16'sh8000 : 16'(-rm);
    else         out16 = (rm > 32767) ? 16'sh7FFF : 16'(rm);
    want.result         = out16;
    want.result_channel = r.channel;
    pending_silu.push_back(want);
  endtask

  function automatic in_item_t make_req(input logic op, input logic [7:0] ch,
                                        input logic [1:0] tap, input logic [15:0] val,
                                        input logic st);
    in_item_t r;
    r.op = op;
    r.channel = ch;
    r.tap = tap;
    r.value = val;
    r.seq_start = st;
    return r;
  endfunction

  // Values lean toward magnitudes that walk through every sigmoid segment,
  // with full-range values and the corners mixed in.
  function automatic logic [15:0] pick_value();
    int s;
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 4))
          0: return 16'h8000;
          1: return 16'hFFFF;
          2: return 16'h0000;
          3: return 16'h0001;
          default: return 16'h7FFF;
        endcase
      end
      1, 2: return 16'($urandom_range(0, 65535));
      default: begin
        s = int'($urandom_range(0, 16384)) - 8192;
        return s[15:0];
      end
    endcase
  endfunction

  // Sends one request. Valid is raised, held with a steady payload until the
  // request is taken, and left high so the next request can follow at once.
  task automatic send_req(input in_item_t r);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= r;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    predict_silu(r);
  endtask

  // A sample must never read a weight that was never loaded, so any tap in
  // use that is still blank gets a random weight first.
  task automatic send_sample(input logic [7:0] ch, input logic [15:0] val,
                             input logic st);
    for (int t = 0; t < taps_in_use(); t++)
      if (!wt_loaded[ch][t])
        send_req(make_req(OP_LOAD, ch, 2'(t), pick_value(), 1'($urandom_range(0, 1))));
    send_req(make_req(OP_SAMPLE, ch, 2'($urandom_range(0, 3)), val, st));
  endtask

  // The tap count may only change while the block is idle: no request is
  // offered, every result is back, and the last request has had time to
  // finish even if it produced no result.
  task automatic write_taps(input logic [2:0] v);
    item_valid <= 1'b0;
    while (pending_silu.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we   <= 1'b0;
    kt_reg = v;
  endtask

  // Corners of the fields and the sigmoid segment edges, four taps in use.
  task automatic test_extremes();
    send_req(make_req(OP_LOAD, 8'd0, 2'd3, 16'd4096, 1'b0));
    send_req(make_req(OP_LOAD, 8'd0, 2'd2, 16'h8000, 1'b1));
    send_req(make_req(OP_LOAD, 8'd0, 2'd1, 16'h7FFF, 1'b0));
    send_req(make_req(OP_LOAD, 8'd0, 2'd0, 16'd1, 1'b0));
    // With a unit weight on the current sample, a sequence start makes the
    // sum equal the sample alone: land on each segment edge and just under the first.
    send_sample(8'd0, 16'd4096, 1'b1);
    send_sample(8'd0, 16'd4095, 1'b1);
    send_sample(8'd0, 16'd9728, 1'b1);
    send_sample(8'd0, 16'd20480, 1'b1);
    send_sample(8'd0, 16'hB000, 1'b1);
    // History now carries over: full-scale samples drive the sum far past the
    // saturation segment, so the output hits its positive limit or zero.
    send_sample(8'd0, 16'h8000, 1'b0);
    send_sample(8'd0, 16'h7FFF, 1'b0);
    send_sample(8'd0, 16'h8000, 1'b0);
    send_sample(8'd0, 16'd0, 1'b1);
    for (int t = 0; t < NTAPS; t++)
      send_req(make_req(OP_LOAD, 8'd255, 2'(t), 16'hFFFF, 1'b0));
    send_sample(8'd255, 16'h7FFF, 1'b1);
    send_sample(8'd255, 16'h8000, 1'b0);
    send_sample(8'd255, 16'hFFFF, 1'b0);
  endtask

  // Tap count register values 1, 2, 0, 3, 5 and 7, including zero and values beyond the
  // maximum. A weight loaded while its tap is unused must still be kept.
  task automatic test_tap_count();
    logic [2:0] counts [6] = '{3'd1, 3'd2, 3'd0, 3'd3, 3'd5, 3'd7};
    foreach (counts[i]) begin
      write_taps(counts[i]);
      if (counts[i] == 3'd2)
        send_req(make_req(OP_LOAD, 8'd0, 2'd3, 16'hE800, 1'b0));
      send_sample(8'd0, pick_value(), 1'($urandom_range(0, 1)));
      send_sample(8'd0, pick_value(), 1'b0);
      send_sample(8'd0, pick_value(), 1'b0);
    end
  endtask

  // Long random stream in phases, one tap count per phase. Most traffic goes
  // to a handful of busy channels so that samples of the same channel arrive
  // back to back and build long sequences; the rest is spread over all
  // channels, and loads that rewrite weights mid-sequence come throughout.
  task automatic test_random_stream();
    logic [2:0] phase_kt [8] = '{3'd4, 3'd1, 3'd3, 3'd2, 3'd0, 3'd6, 3'd7, 3'd4};
    logic [7:0] busy [4];
    logic [7:0] ch;
    foreach (phase_kt[p]) begin
      // The final phase runs with no idling on either side.
      if (p == 7) idle_on = 1'b0;
      write_taps(phase_kt[p]);
      foreach (busy[b]) busy[b] = 8'($urandom_range(0, 255));
      if (p == 1) busy[0] = 8'd255;
      if (p == 2) busy[0] = 8'd0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        ch = ($urandom_range(0, 3) != 0) ? busy[$urandom_range(0, 3)]
                                         : 8'($urandom_range(0, 255));
        if ($urandom_range(0, 9) < 3)
          send_req(make_req(OP_LOAD, ch, 2'($urandom_range(0, 3)), pick_value(),
                            1'($urandom_range(0, 1))));
        else
          send_sample(ch, pick_value(), 1'($urandom_range(0, 11) == 0));
      end
    end
  endtask

  task automatic finish_run();
    item_valid <= 1'b0;
    while (pending_silu.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (errors == 0)
      $display("PASS causal_depthwise_conv_silu_top");
    else
      $display("FAIL causal_depthwise_conv_silu_top");
    $finish;
  endtask

  initial begin
    foreach (hist[c, j]) hist[c][j] = '0;
    foreach (wt_loaded[c, t]) wt_loaded[c][t] = 1'b0;
    foreach (tap_w[c, t]) tap_w[c][t] = '0;
    kt_reg = KT_RESET;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_extremes();
    test_tap_count();
    test_random_stream();
    finish_run();
  end

  // Result side: stalls come in short bursts while idling is enabled.
  always @(posedge clk) begin : res_stall
    int hold;
    if (rst) begin
      hold = 0;
      res_ready <= 1'b0;
    end else if (hold > 0) begin
      hold--;
      res_ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      hold = $urandom_range(0, 3);
      res_ready <= 1'b0;
    end else begin
      res_ready <= 1'b1;
    end
  end

  // Every accepted result is matched against the oldest pending prediction.
  always @(posedge clk) begin : check_results
    out_item_t want;
    if (!rst && res_valid && res_ready) begin
      if (pending_silu.size() == 0) begin
        $display("%0t: unexpected result: result=%0d channel=%0d", $time,
                 $signed(res.result), res.result_channel);
        errors++;
      end else begin
        want = pending_silu.pop_front();
        if (res.result !== want.result) begin
          $display("%0t: result mismatch: expected %0d actual %0d", $time,
                   $signed(want.result), $signed(res.result));
          errors++;
        end
        if (res.result_channel !== want.result_channel) begin
          $display("%0t: channel mismatch: expected %0d actual %0d", $time,
                   want.result_channel, res.result_channel);
          errors++;
        end
      end
    end
  end

  // Watchdog: too many cycles in a row with no handshake on either side.
  always @(posedge clk) begin
    if ((item_valid && item_ready) || (res_valid && res_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("FAIL causal_depthwise_conv_silu_top");
      $finish;
    end
  end

endmodule
